@@ hdl/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and codes for the XOR checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam int unsigned ByteW = 8;

	// Configuration register indexes.
	localparam logic CFG_HEADER_BYTE  = 1'b0;
	localparam logic CFG_LENGTH_LIMIT = 1'b1;

	localparam logic [ByteW-1:0] HeaderReset = 8'd170;
	localparam logic [ByteW-1:0] LimitReset  = 8'd64;

	// Frame outcome reported with every word.
	typedef enum logic [1:0] {
		STAT_NONE     = 2'd0,
		STAT_ACCEPT   = 2'd1,
		STAT_MISMATCH = 2'd2,
		STAT_ABORT    = 2'd3
	} frame_status_t;

	// Configuration as seen by the parser.
	typedef struct packed {
		logic [ByteW-1:0] header_byte;
		logic [ByteW-1:0] length_limit;
	} cfg_t;

	// One result word.
	typedef struct packed {
		frame_status_t    status;
		logic [ByteW-1:0] command;
		logic [ByteW-1:0] argument;
	} result_t;

endpackage

@@ hdl/xor_checked_frame_receiver.sv @@
// Each byte passes the input register, then the result register that offers its word.
// Throughput: one byte per cycle unless in_stall is high; the input and result
// registers let a new byte enter while an earlier result waits behind out_stall.
// Reset (arst_n low, asynchronous): frame state idle, kept bytes zero,
// header byte 170, length limit 64, both pipeline registers empty.
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Byte-wide deframer with header hunt, length limit and XOR check byte.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver
	import xcfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [ByteW-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       frame_status,
	output logic [ByteW-1:0] command,
	output logic [ByteW-1:0] argument
);

	cfg_t             cfg;
	result_t          result;
	logic             valid_s1;
	logic [ByteW-1:0] rx_byte_s1;
	logic             out_valid_q;
	result_t          out_q;
	logic             advance_s1;
	logic             load_s1;

	xcfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage one moves on when the result register is empty or being drained.
	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign load_s1    = in_valid && !in_stall;

	xcfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_en    (advance_s1),
		.rx_byte_s1 (rx_byte_s1),
		.result     (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || advance_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = out_q.status;
	assign command      = out_q.command;
	assign argument     = out_q.argument;

	// Input is held off only while a word waits behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// A processed byte always lands in the result register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> out_valid_q)
		else $error("processed byte produced no result word");

	// Kept bytes are only shown with an accepted frame.
	a_kept_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != STAT_ACCEPT) |->
			(out_q.command == '0 && out_q.argument == '0))
		else $error("kept bytes shown without an accepted frame");

endmodule

@@ hdl/xcfr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// xcfr_cfg_regs
// Header byte and length limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module xcfr_cfg_regs
	import xcfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [ByteW-1:0] cfg_data,
	output cfg_t             cfg
);

	logic [ByteW-1:0] header_q;
	logic [ByteW-1:0] limit_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HeaderReset;
			limit_q  <= LimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_BYTE:  header_q <= cfg_data;
				CFG_LENGTH_LIMIT: limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.header_byte  = header_q;
	assign cfg.length_limit = limit_q;

endmodule

@@ hdl/xcfr_parser.sv @@
// ----------------------------------------------------------------------------
// xcfr_parser
// Frame state and the single-pass step that turns one byte into one result.
// ----------------------------------------------------------------------------
module xcfr_parser
	import xcfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step_en,
	input  logic [ByteW-1:0] rx_byte_s1,
	output result_t          result
);

	logic [ByteW-1:0] pos_q, pos_d;
	logic [ByteW-1:0] len_q, len_d;
	logic [ByteW-1:0] xor_q, xor_d;
	logic [ByteW-1:0] cmd_q, cmd_d;
	logic [ByteW-1:0] arg_q, arg_d;
	logic [ByteW:0]   pos_inc;

	assign pos_inc = {1'b0, pos_q} + {{ByteW{1'b0}}, 1'b1};

	// Next state and result for the byte in the input register.
	always_comb begin
		pos_d  = pos_q;
		len_d  = len_q;
		xor_d  = xor_q;
		cmd_d  = cmd_q;
		arg_d  = arg_q;
		result = '{status: STAT_NONE, command: '0, argument: '0};
		if (pos_q == '0) begin
			// Hunt for the header byte.
			if (rx_byte_s1 == cfg.header_byte) begin
				pos_d = ByteW'(1);
				xor_d = cfg.header_byte;
			end
		end else if (pos_q == ByteW'(1)) begin
			// Length byte, checked against the limit.
			if (rx_byte_s1 < cfg.length_limit) begin
				len_d = rx_byte_s1;
				xor_d = xor_q ^ rx_byte_s1;
				pos_d = ByteW'(2);
			end else begin
				pos_d = '0;
				len_d = '0;
				xor_d = '0;
				result.status = STAT_ABORT;
			end
		end else if (pos_inc < {1'b0, len_q}) begin
			// Body byte; the first two are kept.
			if (pos_q == ByteW'(2)) begin
				cmd_d = rx_byte_s1;
			end else if (pos_q == ByteW'(3)) begin
				arg_d = rx_byte_s1;
			end
			pos_d = pos_inc[ByteW-1:0];
			xor_d = xor_q ^ rx_byte_s1;
		end else if (pos_inc == {1'b0, len_q}) begin
			// Check byte closes the frame.
			if (xor_q == rx_byte_s1) begin
				result.status   = STAT_ACCEPT;
				result.command  = cmd_q;
				result.argument = arg_q;
			end else begin
				result.status = STAT_MISMATCH;
			end
			pos_d = '0;
			len_d = '0;
			xor_d = '0;
		end else begin
			// Length too short for a check byte.
			pos_d = '0;
			len_d = '0;
			xor_d = '0;
			result.status = STAT_ABORT;
		end
	end

	// Frame state registers, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			xor_q <= '0;
			cmd_q <= '0;
			arg_q <= '0;
		end else if (step_en) begin
			pos_q <= pos_d;
			len_q <= len_d;
			xor_q <= xor_d;
			cmd_q <= cmd_d;
			arg_q <= arg_d;
		end
	end

	// Idle always leaves the checksum cleared.
	a_idle_xor_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> xor_q == '0)
		else $error("running checksum not cleared while idle");

	// The body position only advances while a check byte is still ahead.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q > ByteW'(2) |-> pos_q < len_q)
		else $error("byte position ran past the frame length");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XOR checked frame receiver. Bytes go in through
// a valid/stall channel with random bursts and gaps. A behavioral deframer
// predicts one result word per accepted byte, and the result channel is
// compared field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
	import xcfr_pkg::*;

	localparam int ItemsTarget = 1650;
	localparam int FullFrame   = 1000;
	localparam int HoldCycles  = 60;
	localparam int DrainCycles = 4;

	typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [ByteW-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [ByteW-1:0] rx_byte;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       frame_status;
	logic [ByteW-1:0] command;
	logic [ByteW-1:0] argument;

	// Deframer state and configuration as the bench tracks it.
	logic [ByteW-1:0] cfg_hdr   = HeaderReset;
	logic [ByteW-1:0] cfg_limit = LimitReset;
	logic [ByteW-1:0] rx_pos    = '0;
	logic [ByteW-1:0] rx_len    = '0;
	logic [ByteW-1:0] rx_xor    = '0;
	logic [ByteW-1:0] held_cmd  = '0;
	logic [ByteW-1:0] held_arg  = '0;

	result_t pending_results[$];
	int      err_count    = 0;
	int      bytes_counted = 0;
	int      burst_left   = 0;
	bit      gaps_on      = 1'b1;
	int      hold_request = 0;

	xor_checked_frame_receiver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.command      (command),
		.argument     (argument)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void frame_to_idle();
		rx_pos = '0;
		rx_len = '0;
		rx_xor = '0;
	endfunction

	// Advance the frame state by one byte and return the word it reports.
	function automatic result_t deframe_byte(input logic [ByteW-1:0] b);
		result_t r;
		int      pos;
		int      len;
		r.status   = STAT_NONE;
		r.command  = '0;
		r.argument = '0;
		pos = rx_pos;
		len = rx_len;
		if (pos == 0) begin
			if (b == cfg_hdr) begin
				rx_pos = 8'd1;
				rx_xor = cfg_hdr;
			end
		end else if (pos == 1) begin
			if (b < cfg_limit) begin
				rx_len = b;
				rx_xor = rx_xor ^ b;
				rx_pos = 8'd2;
			end else begin
				frame_to_idle();
				r.status = STAT_ABORT;
			end
		end else if (len >= 1 && pos + 1 < len) begin
			if (pos == 2)
				held_cmd = b;
			else if (pos == 3)
				held_arg = b;
			rx_pos = rx_pos + 8'd1;
			rx_xor = rx_xor ^ b;
		end else if (len >= 1 && pos + 1 == len) begin
			if (rx_xor == b) begin
				r.status   = STAT_ACCEPT;
				r.command  = held_cmd;
				r.argument = held_arg;
			end else begin
				r.status = STAT_MISMATCH;
			end
			frame_to_idle();
		end else begin
			frame_to_idle();
			r.status = STAT_ABORT;
		end
		return r;
	endfunction

	// Offer one byte, honoring the burst/gap pattern, and record its word once taken.
	task automatic send_byte(input logic [ByteW-1:0] b);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Bytes hunted over while idle do not count toward the traffic volume.
		if (!(rx_pos == 0 && b != cfg_hdr))
			bytes_counted++;
		pending_results.push_back(deframe_byte(b));
		if (burst_left > 0)
			burst_left--;
	endtask

	// Build a frame of total length len and send the first n_send bytes of it.
	task automatic send_frame(input int len, input logic [ByteW-1:0] cmd, arg, flip,
		input int n_send);
		logic [ByteW-1:0] frame_bytes[$];
		logic [ByteW-1:0] sum;
		logic [ByteW-1:0] b;
		frame_bytes.push_back(cfg_hdr);
		frame_bytes.push_back(8'(len));
		if (len < cfg_limit) begin
			if (len < 3) begin
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				sum = cfg_hdr ^ 8'(len);
				for (int p = 2; p < len - 1; p++) begin
					if (p == 2)
						b = cmd;
					else if (p == 3)
						b = arg;
					else
						b = 8'($urandom_range(0, 255));
					frame_bytes.push_back(b);
					sum = sum ^ b;
				end
				frame_bytes.push_back(sum ^ flip);
			end
		end
		for (int i = 0; i < frame_bytes.size() && i < n_send; i++)
			send_byte(frame_bytes[i]);
	endtask

	// Let every expected word arrive, then give the pipeline time to settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write both registers while the block is idle.
	task automatic set_config(input logic [ByteW-1:0] hdr, limit);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HEADER_BYTE;
		cfg_data  <= hdr;
		@(posedge clk);
		cfg_index <= CFG_LENGTH_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cfg_hdr   = hdr;
		cfg_limit = limit;
	endtask

	// Field extremes, stale kept bytes, short, rejected and mismatched frames.
	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(3, 8'h11, 8'h22, 8'h00, FullFrame);
		send_frame(5, 8'h00, 8'hFF, 8'h00, FullFrame);
		send_frame(4, 8'hFF, 8'h00, 8'h00, FullFrame);
		send_frame(5, 8'h33, 8'hCC, 8'h80, FullFrame);
		send_frame(0, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(2, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(64, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(255, 8'h00, 8'h00, 8'h00, FullFrame);
	endtask

	// Register extremes: widest limit, limit zero, a tiny limit.
	task automatic test_register_extremes();
		set_config(8'h00, 8'hFF);
		send_frame(5, 8'hA5, 8'h5A, 8'h00, FullFrame);
		send_frame(254, 8'h01, 8'h02, 8'h00, FullFrame);
		send_frame(255, 8'h00, 8'h00, 8'h00, FullFrame);
		set_config(8'hFF, 8'h00);
		send_frame(0, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(5, 8'h12, 8'h34, 8'h00, FullFrame);
		send_byte(8'h00);
		set_config(8'h3C, 8'h04);
		send_frame(3, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(1, 8'h00, 8'h00, 8'h00, FullFrame);
		send_frame(3, 8'h00, 8'h00, 8'h01, FullFrame);
		send_frame(4, 8'h77, 8'h00, 8'h00, FullFrame);
		set_config(HeaderReset, LimitReset);
	endtask

	// Long receiver hold-off while bytes keep coming back to back.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = HoldCycles;
		for (int f = 0; f < 5; f++)
			send_frame(8, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h00,
				FullFrame);
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed frames with random content, plus broken ones, noise and register changes.
	task automatic test_random_traffic();
		int kind;
		int len;
		int pick;
		logic [ByteW-1:0] new_limit;
		while (bytes_counted < ItemsTarget) begin
			if ($urandom_range(0, 39) == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					new_limit = LimitReset;
				else if (pick < 5)
					new_limit = 8'hFF;
				else if (pick < 8)
					new_limit = 8'($urandom_range(16, 128));
				else
					new_limit = 8'($urandom_range(0, 4));
				pick = $urandom_range(0, 3);
				set_config(pick == 0 ? HeaderReset : pick == 1 ? 8'h00 :
					pick == 2 ? 8'hFF : 8'($urandom_range(0, 255)), new_limit);
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 88)
				len = $urandom_range(3, 12);
			else if (pick < 99)
				len = $urandom_range(13, 70);
			else
				len = $urandom_range(71, 254);
			kind = $urandom_range(0, 99);
			if (kind < 70)
				send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'h00, FullFrame);
			else if (kind < 80)
				send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(1, 255)), FullFrame);
			else if (kind < 87)
				send_frame($urandom_range(0, 2), 8'h00, 8'h00, 8'h00, FullFrame);
			else if (kind < 92)
				send_frame($urandom_range(cfg_limit, 255), 8'h00, 8'h00, 8'h00, FullFrame);
			else if (kind < 96)
				send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'h00, $urandom_range(2, len - 1));
			else
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver stall pattern, with a counted hold-off on request.
	initial begin : rx_stall_pattern
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       phase;
		out_stall <= 1'b0;
		mode = RX_FLOW;
		mode_left = 0;
		hold_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_FLOW:     out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: out_stall <= ((phase % 7) < 3);
					default:     out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: frame_status %0d command %0h argument %0h",
					frame_status, command, argument);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (frame_status !== want.status) begin
					$error("frame_status: expected %0d, actual %0d", want.status, frame_status);
					err_count++;
				end
				if (command !== want.command) begin
					$error("command: expected %0h, actual %0h", want.command, command);
					err_count++;
				end
				if (argument !== want.argument) begin
					$error("argument: expected %0h, actual %0h", want.argument, argument);
					err_count++;
				end
			end
		end
	end

	initial begin : run_tests
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_HEADER_BYTE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		rx_byte   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		drain_results();
		if (err_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
